// ===== src/bpfa_pkg.sv =====
// Package for the bitmap page frame allocator.
// Holds the request and response word types, function and status codes and defaults.
// No dependencies.
package bpfa_pkg;

    // Default geometry; both must be powers of two, with at least two bitmap words.
    localparam int NUM_FRAMES_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;

    // Fixed field widths of the request and response words.
    localparam int CFG_W   = 8;
    localparam int FRAME_W = 12;
    localparam int COUNT_W = 13;

    // Number of bitmap words in use after reset.
    localparam logic [CFG_W-1:0] WORDS_RESET = 8'd128;

    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_FREE    = 2'd1,
        FUNC_RESERVE = 2'd2,
        FUNC_QUERY   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_NOMEM = 2'd1,
        STAT_ZERO  = 2'd2
    } status_t;

    typedef struct packed {
        func_t                func;
        logic [FRAME_W-1:0]   start_frame;
        logic [COUNT_W-1:0]   page_count;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [FRAME_W-1:0]   frame;
        logic [COUNT_W-1:0]   free_count;
        logic [COUNT_W-1:0]   used_count;
    } rsp_t;

endpackage

// ===== src/bitmap_page_frame_allocator_unit.sv =====
// Top level of the bitmap first-fit page frame allocator: sequencer, config and response register.
// Depends on bpfa_pkg, bpfa_bitmap_mem and bpfa_word_unit.
//
//  channel | signals                        | word
//  --------+--------------------------------+------------------------------------
//  req     | req_valid, req_ready, req      | func, start_frame, page_count
//  rsp     | rsp_valid, rsp_ready, rsp      | status, frame, free_count, used_count
//  cfg     | cfg_valid, cfg_ready, cfg_data | bitmap_words (always ready)
//
// After reset the bitmap is cleared one word per cycle, all NUM_FRAMES / WORD_BITS words
// (128 by default), with req_ready low.
// Query scans the words in use; allocate scans the words up to the hit, then marks
// the words the run covers; free and reserve mark the words covered.
// Zero counts and out-of-range starts go straight to the response. The sequencer reads
// one bitmap word per cycle through the memory read port.
// A new request is taken while the previous response waits; a finished result then
// waits in its last step until the response register frees up.
module bitmap_page_frame_allocator_unit #(
    parameter int NUM_FRAMES = bpfa_pkg::NUM_FRAMES_DEF,
    parameter int WORD_BITS  = bpfa_pkg::WORD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  bpfa_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output bpfa_pkg::rsp_t             rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bpfa_pkg::CFG_W-1:0] cfg_data
);
    import bpfa_pkg::*;

    localparam int DEPTH = NUM_FRAMES / WORD_BITS;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(WORD_BITS);
    localparam int FW    = $clog2(NUM_FRAMES);
    localparam int CW    = $clog2(NUM_FRAMES + 1);
    localparam int PW    = $clog2(WORD_BITS + 1);
    localparam int XW    = ((FW > COUNT_W) ? FW : COUNT_W) + 1;
    localparam logic [WORD_BITS-1:0] ALL = '1;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_MARK  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    // Control registers.
    state_t             state_reg, state_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [CFG_W-1:0]   words_reg;

    // Working registers of the current request.
    func_t              func_reg, func_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [COUNT_W-1:0] run_reg, run_next;
    logic [AW-1:0]      last_reg, last_next;
    logic [FW-1:0]      lo_reg, lo_next;
    logic [FW-1:0]      hi_reg, hi_next;
    logic [FW-1:0]      first_reg, first_next;
    logic               set_reg, set_next;
    status_t            status_reg, status_next;
    logic [CW-1:0]      free_acc_reg, free_acc_next;
    logic [CW-1:0]      used_acc_reg, used_acc_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_load;

    // Memory ports.
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [AW-1:0]      rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    // Word unit results.
    logic               u_hit;
    logic [BW-1:0]      u_hit_pos;
    logic [COUNT_W-1:0] u_run_next;
    logic [PW-1:0]      u_pop;

    // Request decode helpers.
    logic [31:0]        lim32;
    logic [AW-1:0]      last_word;
    logic [XW-1:0]      s_ext;
    logic [XW-1:0]      e_ext;
    logic               start_oob;
    logic [FW-1:0]      hi_clip;

    // Scan and mark helpers.
    logic [FW-1:0]      cur_frame;
    logic [XW-1:0]      first_ext;
    logic [AW-1:0]      lo_w;
    logic [AW-1:0]      hi_w;
    logic [BW-1:0]      lo_bit;
    logic [BW-1:0]      hi_bit;
    logic [WORD_BITS-1:0] mask;

    // Response staging.
    logic [31:0]        frame32;
    logic [31:0]        free32;
    logic [31:0]        used32;

    bpfa_bitmap_mem #(
        .WORD_BITS (WORD_BITS),
        .DEPTH     (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bpfa_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_unit (
        .word     (rd_data),
        .cnt      (cnt_reg),
        .run      (run_reg),
        .hit      (u_hit),
        .hit_pos  (u_hit_pos),
        .run_next (u_run_next),
        .pop      (u_pop)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Words in use, saturated to the store depth.
    assign lim32     = (32'(words_reg) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(words_reg);
    assign last_word = AW'(lim32 - 32'd1);

    // Free and reserve range, clipped at the end of the bitmap.
    assign s_ext     = XW'(req.start_frame);
    assign e_ext     = s_ext + XW'(req.page_count) - XW'(1);
    assign start_oob = (s_ext >= XW'(NUM_FRAMES));
    assign hi_clip   = (e_ext >= XW'(NUM_FRAMES)) ? FW'(NUM_FRAMES - 1) : e_ext[FW-1:0];

    // First frame of a run that ends at the hit position.
    assign cur_frame = {cur_reg, u_hit_pos};
    assign first_ext = XW'(cur_frame) + XW'(1) - XW'(cnt_reg);

    // Bit mask of the range inside the current word.
    assign lo_w   = lo_reg[FW-1:BW];
    assign hi_w   = hi_reg[FW-1:BW];
    assign lo_bit = (cur_reg == lo_w) ? lo_reg[BW-1:0] : '0;
    assign hi_bit = (cur_reg == hi_w) ? hi_reg[BW-1:0] : BW'(WORD_BITS - 1);
    assign mask   = (ALL >> (BW'(WORD_BITS - 1) - hi_bit)) & (ALL << lo_bit);

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        func_next     = func_reg;
        cnt_next      = cnt_reg;
        run_next      = run_reg;
        last_next     = last_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        first_next    = first_reg;
        set_next      = set_reg;
        status_next   = status_reg;
        free_acc_next = free_acc_reg;
        used_acc_next = used_acc_reg;
        rsp_load      = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = cur_reg;
        wr_data       = '0;
        rd_addr       = cur_reg + AW'(1);

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                cur_next = cur_reg + AW'(1);
                if (cur_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next     = req.func;
                    cnt_next      = req.page_count;
                    run_next      = '0;
                    first_next    = '0;
                    free_acc_next = '0;
                    used_acc_next = '0;
                    status_next   = STAT_DONE;
                    cur_next      = '0;
                    last_next     = last_word;
                    set_next      = (req.func == FUNC_RESERVE);
                    unique case (req.func) inside
                        FUNC_ALLOC, FUNC_QUERY:
                        begin
                            rd_addr = '0;
                            if (req.func == FUNC_ALLOC && req.page_count == '0)
                            begin
                                status_next = STAT_ZERO;
                                state_next  = S_DONE;
                            end
                            else if (words_reg == '0)
                            begin
                                if (req.func == FUNC_ALLOC)
                                begin
                                    status_next = STAT_NOMEM;
                                end
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        FUNC_FREE, FUNC_RESERVE:
                        begin
                            rd_addr = s_ext[FW-1:BW];
                            if (req.page_count == '0)
                            begin
                                status_next = STAT_ZERO;
                                state_next  = S_DONE;
                            end
                            else if (start_oob)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                lo_next    = s_ext[FW-1:0];
                                hi_next    = hi_clip;
                                cur_next   = s_ext[FW-1:BW];
                                state_next = S_MARK;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (func_reg == FUNC_ALLOC)
                begin
                    if (u_hit)
                    begin
                        // Run found: go back to its first word and mark it used.
                        first_next = first_ext[FW-1:0];
                        lo_next    = first_ext[FW-1:0];
                        hi_next    = cur_frame;
                        cur_next   = first_ext[FW-1:BW];
                        rd_addr    = first_ext[FW-1:BW];
                        set_next   = 1'b1;
                        state_next = S_MARK;
                    end
                    else if (cur_reg == last_reg)
                    begin
                        status_next = STAT_NOMEM;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        run_next = u_run_next;
                        cur_next = cur_reg + AW'(1);
                    end
                end
                else
                begin
                    free_acc_next = free_acc_reg + CW'(WORD_BITS) - CW'(u_pop);
                    used_acc_next = used_acc_reg + CW'(u_pop);
                    if (cur_reg == last_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cur_next = cur_reg + AW'(1);
                    end
                end
            end

            S_MARK:
            begin
                // Read-modify-write of the current word while the next one is read.
                wr_en   = 1'b1;
                wr_data = set_reg ? (rd_data | mask) : (rd_data & ~mask);
                if (cur_reg == hi_w)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next = cur_reg + AW'(1);
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response word assembly; fields are cut to their port widths.
    assign frame32 = 32'(first_reg);
    assign free32  = 32'(free_acc_reg);
    assign used32  = 32'(used_acc_reg);

    always_comb
    begin
        rsp_next.status     = status_reg;
        rsp_next.frame      = frame32[FRAME_W-1:0];
        rsp_next.free_count = free32[COUNT_W-1:0];
        rsp_next.used_count = used32[COUNT_W-1:0];
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cur_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            words_reg     <= WORDS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                words_reg <= cfg_data;
            end
        end
    end

    // Working registers without reset.
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        cnt_reg      <= cnt_next;
        run_reg      <= run_next;
        last_reg     <= last_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        first_reg    <= first_next;
        set_reg      <= set_next;
        status_reg   <= status_next;
        free_acc_reg <= free_acc_next;
        used_acc_reg <= used_acc_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // An accepted request always leaves the idle state.
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // The carried run stays shorter than the requested count while scanning.
    a_run_below_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && func_reg == FUNC_ALLOC) |-> (run_reg < cnt_reg))
        else $error("carried free run reached the count without a hit");

    // Marking never walks past the last word of its range.
    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |-> (cur_reg >= lo_w && cur_reg <= hi_w))
        else $error("mark pass outside its word range");

    // Counts are only reported with a successful status.
    a_counts_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != STAT_DONE) |->
        (rsp.free_count == '0 && rsp.used_count == '0 && rsp.frame == '0))
        else $error("failed or empty response carries nonzero fields");

endmodule

// ===== src/bpfa_bitmap_mem.sv =====
// Bitmap store: one write port and one registered read port.
// Standalone; no package needed.
module bpfa_bitmap_mem #(
    parameter int WORD_BITS = 32,
    parameter int DEPTH     = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WORD_BITS-1:0]     wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WORD_BITS-1:0]     rd_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    // Write when enabled and read every cycle; the sequencer never reads the word it writes.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/bpfa_word_unit.sv =====
// Shared word unit: run search, trailing free run and population count for one bitmap word.
// Depends on bpfa_pkg.
module bpfa_word_unit #(
    parameter int WORD_BITS = bpfa_pkg::WORD_BITS_DEF
) (
    input  logic [WORD_BITS-1:0]               word,
    input  logic [bpfa_pkg::COUNT_W-1:0]       cnt,
    input  logic [bpfa_pkg::COUNT_W-1:0]       run,
    output logic                               hit,
    output logic [$clog2(WORD_BITS)-1:0]       hit_pos,
    output logic [bpfa_pkg::COUNT_W-1:0]       run_next,
    output logic [$clog2(WORD_BITS+1)-1:0]     pop
);
    import bpfa_pkg::*;

    localparam int BW = $clog2(WORD_BITS);
    localparam int PW = $clog2(WORD_BITS + 1);
    localparam logic [WORD_BITS-1:0] ALL = '1;

    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] lvl [BW+1];
    logic [WORD_BITS-1:0] win;
    logic [WORD_BITS-1:0] carry_hit;
    logic [WORD_BITS-1:0] hit_vec;
    logic [COUNT_W-1:0]   need_m1;
    logic [PW-1:0]        top_free;
    logic                 in_word;

    assign free_bits = ~word;

    // Frames still needed beyond the run carried in from lower words, minus one.
    assign need_m1 = cnt - run - COUNT_W'(1);
    assign in_word = (cnt <= COUNT_W'(WORD_BITS));

    // Level k marks positions that end a free window of 2**k frames.
    always_comb
    begin
        lvl[0] = free_bits;
        for (int k = 1; k <= BW; k++)
        begin
            lvl[k] = lvl[k-1] & (lvl[k-1] << (1 << (k - 1)));
        end
    end

    // Combine the levels picked by the bits of the count into a window of cnt frames.
    always_comb
    begin
        logic have;
        have = 1'b0;
        win  = ALL;
        for (int k = 0; k <= BW; k++)
        begin
            if (cnt[k])
            begin
                if (have)
                begin
                    win = lvl[k] & (win << (1 << k));
                end
                else
                begin
                    win = lvl[k];
                end
                have = 1'b1;
            end
        end
    end

    // A position also completes a run when every frame up to and including it in this word
    // is free and the run carried in is long enough.
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            carry_hit[b] = ((word & (ALL >> (WORD_BITS - 1 - b))) == '0) &&
                           (COUNT_W'(b) >= need_m1);
        end
    end

    assign hit_vec = carry_hit | (in_word ? win : '0);
    assign hit     = |hit_vec;

    // Lowest position that completes a run.
    always_comb
    begin
        hit_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (hit_vec[b])
            begin
                hit_pos = BW'(b);
            end
        end
    end

    // Free frames above the highest used frame.
    always_comb
    begin
        top_free = PW'(WORD_BITS);
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (word[b])
            begin
                top_free = PW'(WORD_BITS - 1 - b);
            end
        end
    end

    assign run_next = (word == '0) ? run + COUNT_W'(WORD_BITS) : COUNT_W'(top_free);
    assign pop      = PW'($countones(word));

endmodule
